@@ rtl/palindromic_tree_builder_macros.svh @@
// Assertion macros shared by the palindromic tree builder.
`ifndef PALINDROMIC_TREE_BUILDER_MACROS_SVH
`define PALINDROMIC_TREE_BUILDER_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define PTB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the active-low reset is asserted.
`define PTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ptb_pkg.sv @@
// Types, constants and helpers of the palindromic tree builder.
`timescale 1ns / 1ps
package ptb_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int ALPHABET    = 26;
    localparam int NODE_CAP    = MAX_LEN + 2;
    localparam int EDGE_DEPTH  = NODE_CAP * ALPHABET;
    localparam int HIST_DEPTH  = MAX_LEN + 1;
    localparam int NODE_W      = $clog2(NODE_CAP);
    localparam int POS_W       = $clog2(HIST_DEPTH);
    localparam int LEN_W       = 11;
    localparam int SYM_W       = 5;
    localparam int EDGE_AW     = $clog2(EDGE_DEPTH);
    localparam int CODE_W      = 7;

    localparam logic [CODE_W-1:0] CHAR_A     = CODE_W'(97);
    localparam logic [CODE_W-1:0] CHAR_END   = CODE_W'(97 + ALPHABET);
    localparam logic [NODE_W-1:0] ROOT_EMPTY = NODE_W'(0);
    localparam logic [NODE_W-1:0] ROOT_IMAG  = NODE_W'(1);

    // One node of the tree as kept in the node memory.
    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [NODE_W-1:0] parent;
        logic [LEN_W-1:0]  depth;
        logic [LEN_W-1:0]  len;
        logic [NODE_W-1:0] link;
    } t_node;

    typedef struct packed {
        logic              we;
        logic [POS_W-1:0]  waddr;
        logic [SYM_W-1:0]  wdata;
        logic [POS_W-1:0]  raddr;
    } t_lh_req;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        t_node             wdata;
        logic [NODE_W-1:0] raddr;
    } t_node_req;

    typedef struct packed {
        logic               we;
        logic [EDGE_AW-1:0] waddr;
        logic [NODE_W-1:0]  wdata;
        logic [EDGE_AW-1:0] raddr;
    } t_edge_req;

    // Output word, first field in the highest bits.
    typedef struct packed {
        logic             overflow;
        logic             created;
        logic [LEN_W-1:0] count;
        logic [LEN_W-1:0] len;
    } t_result;

    function automatic logic [EDGE_AW-1:0] edge_addr(input logic [NODE_W-1:0] node,
                                                    input logic [SYM_W-1:0] sym);
        logic [EDGE_AW-1:0] base;
        base = EDGE_AW'(node) * EDGE_AW'(ALPHABET);
        return base + EDGE_AW'(sym);
    endfunction

endpackage

@@ rtl/ptb_ram.sv @@
// Simple dual-port synchronous RAM with a registered read.
`timescale 1ns / 1ps
module ptb_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/ptb_seq.sv @@
// Sequencer that walks suffix links and updates the tree held in the memories.
`timescale 1ns / 1ps
module ptb_seq import ptb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [6:0] char_code
    input  logic              i_s_tuser,   // restart
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [23:0]       o_m_tdata,   // [10:0] len, [21:11] count, [22] created, [23] overflow
    output t_lh_req           o_lh_req,
    input  logic [SYM_W-1:0]  i_lh_rdata,
    output t_node_req         o_node_req,
    input  t_node             i_node_rdata,
    output t_edge_req         o_edge_req,
    input  logic [NODE_W-1:0] i_edge_rdata
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_WRD  = 4'd2;
    localparam logic [3:0] S_WLEN = 4'd3;
    localparam logic [3:0] S_WCMP = 4'd4;
    localparam logic [3:0] S_E1   = 4'd5;
    localparam logic [3:0] S_E2   = 4'd6;
    localparam logic [3:0] S_NEW  = 4'd7;
    localparam logic [3:0] S_L1   = 4'd8;
    localparam logic [3:0] S_L2   = 4'd9;
    localparam logic [3:0] S_WR   = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]          r_state,    n_state;
    logic [EDGE_AW-1:0]  r_clr,      n_clr;
    logic [NODE_W-1:0]   r_x,        n_x;
    logic [POS_W-1:0]    r_n,        n_n;
    logic [NODE_W-1:0]   r_total,    n_total;
    logic [NODE_W-1:0]   r_last,     n_last;
    logic [SYM_W-1:0]    r_sym,      n_sym;
    logic                r_phase,    n_phase;
    logic                r_force,    n_force;
    logic signed [LEN_W:0] r_xlen,   n_xlen;
    logic [NODE_W-1:0]   r_xlink,    n_xlink;
    logic [NODE_W-1:0]   r_cur,      n_cur;
    logic signed [LEN_W:0] r_cur_len, n_cur_len;
    logic [NODE_W-1:0]   r_cur_link, n_cur_link;
    logic [NODE_W-1:0]   r_child,    n_child;
    logic [NODE_W-1:0]   r_link,     n_link;
    logic [LEN_W-1:0]    r_ldepth,   n_ldepth;
    t_result             r_res,      n_res;
    t_result             r_out,      n_out;
    logic                r_out_valid, n_out_valid;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    always_comb begin
        logic [NODE_W-1:0]     total_eff;
        logic [NODE_W-1:0]     last_eff;
        logic [POS_W-1:0]      n_eff;
        logic [CODE_W-1:0]     code;
        logic signed [LEN_W:0] x_len;
        logic [NODE_W-1:0]     x_link;
        logic signed [LEN_W:0] pos;

        n_state     = r_state;
        n_clr       = r_clr;
        n_x         = r_x;
        n_n         = r_n;
        n_total     = r_total;
        n_last      = r_last;
        n_sym       = r_sym;
        n_phase     = r_phase;
        n_force     = r_force;
        n_xlen      = r_xlen;
        n_xlink     = r_xlink;
        n_cur       = r_cur;
        n_cur_len   = r_cur_len;
        n_cur_link  = r_cur_link;
        n_child     = r_child;
        n_link      = r_link;
        n_ldepth    = r_ldepth;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;
        o_lh_req    = '0;
        o_node_req  = '0;
        o_edge_req  = '0;

        total_eff = i_s_tuser ? NODE_W'(2) : r_total;
        last_eff  = i_s_tuser ? ROOT_EMPTY : r_last;
        n_eff     = i_s_tuser ? '0 : r_n;
        code      = i_s_tdata[CODE_W-1:0];

        // The two roots never live in memory.
        if (r_x == ROOT_EMPTY) begin
            x_len  = '0;
            x_link = ROOT_IMAG;
        end else if (r_x == ROOT_IMAG) begin
            x_len  = -(LEN_W+1)'(1);
            x_link = ROOT_EMPTY;
        end else begin
            x_len  = $signed({1'b0, i_node_rdata.len});
            x_link = i_node_rdata.link;
        end
        pos = $signed({1'b0, r_n}) - x_len - (LEN_W+1)'(1);

        case (r_state)
            S_CLR: begin
                o_edge_req.we    = 1'b1;
                o_edge_req.waddr = r_clr;
                if (r_clr == EDGE_AW'(EDGE_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + EDGE_AW'(1);
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_total = total_eff;
                    n_last  = last_eff;
                    n_n     = n_eff;
                    n_res   = '0;
                    if (n_eff >= POS_W'(MAX_LEN)) begin
                        n_res.overflow = 1'b1;
                        n_state        = S_OUT;
                    end else if (code < CHAR_A || code >= CHAR_END) begin
                        n_state = S_OUT;
                    end else begin
                        n_n              = n_eff + POS_W'(1);
                        n_sym            = SYM_W'(code - CHAR_A);
                        o_lh_req.we      = 1'b1;
                        o_lh_req.waddr   = n_eff + POS_W'(1);
                        o_lh_req.wdata   = SYM_W'(code - CHAR_A);
                        n_x              = last_eff;
                        n_phase          = 1'b0;
                        n_state          = S_WRD;
                    end
                end
            end
            S_WRD: begin
                o_node_req.raddr = r_x;
                n_state          = S_WLEN;
            end
            S_WLEN: begin
                n_xlen  = x_len;
                n_xlink = x_link;
                if (r_x == ROOT_IMAG) begin
                    n_force = 1'b1;
                    n_state = S_WCMP;
                end else if (pos <= 0) begin
                    // Position zero holds the sentinel, which matches nothing.
                    n_x     = x_link;
                    n_state = S_WRD;
                end else begin
                    o_lh_req.raddr = POS_W'(pos);
                    n_force        = 1'b0;
                    n_state        = S_WCMP;
                end
            end
            S_WCMP: begin
                if (r_force || i_lh_rdata == r_sym) begin
                    o_edge_req.raddr = edge_addr(r_x, r_sym);
                    if (!r_phase) begin
                        n_cur      = r_x;
                        n_cur_len  = r_xlen;
                        n_cur_link = r_xlink;
                        n_state    = S_E1;
                    end else begin
                        n_state = S_L1;
                    end
                end else begin
                    n_x     = r_xlink;
                    n_state = S_WRD;
                end
            end
            S_E1: begin
                // An entry is only trusted if the child it names was built from this row.
                if (i_edge_rdata >= NODE_W'(2) && i_edge_rdata < r_total) begin
                    o_node_req.raddr = i_edge_rdata;
                    n_child          = i_edge_rdata;
                    n_state          = S_E2;
                end else begin
                    n_state = S_NEW;
                end
            end
            S_E2: begin
                if (i_node_rdata.parent == r_cur && i_node_rdata.sym == r_sym) begin
                    n_res.len   = i_node_rdata.len;
                    n_res.count = i_node_rdata.depth;
                    n_last      = r_child;
                    n_state     = S_OUT;
                end else begin
                    n_state = S_NEW;
                end
            end
            S_NEW: begin
                if (r_total >= NODE_W'(NODE_CAP)) begin
                    n_last  = ROOT_EMPTY;
                    n_state = S_OUT;
                end else if (r_cur == ROOT_IMAG) begin
                    n_link   = ROOT_EMPTY;
                    n_ldepth = '0;
                    n_state  = S_WR;
                end else begin
                    n_x     = r_cur_link;
                    n_phase = 1'b1;
                    n_state = S_WRD;
                end
            end
            S_L1: begin
                n_link = i_edge_rdata;
                if (i_edge_rdata >= NODE_W'(2)) begin
                    o_node_req.raddr = i_edge_rdata;
                    n_state          = S_L2;
                end else begin
                    n_ldepth = '0;
                    n_state  = S_WR;
                end
            end
            S_L2: begin
                n_ldepth = i_node_rdata.depth;
                n_state  = S_WR;
            end
            S_WR: begin
                o_node_req.we           = 1'b1;
                o_node_req.waddr        = r_total;
                o_node_req.wdata.link   = r_link;
                o_node_req.wdata.len    = LEN_W'(r_cur_len + (LEN_W+1)'(2));
                o_node_req.wdata.depth  = r_ldepth + LEN_W'(1);
                o_node_req.wdata.parent = r_cur;
                o_node_req.wdata.sym    = r_sym;
                o_edge_req.we           = 1'b1;
                o_edge_req.waddr        = edge_addr(r_cur, r_sym);
                o_edge_req.wdata        = r_total;
                n_res.len               = LEN_W'(r_cur_len + (LEN_W+1)'(2));
                n_res.count             = r_ldepth + LEN_W'(1);
                n_res.created           = 1'b1;
                n_last                  = r_total;
                n_total                 = r_total + NODE_W'(1);
                n_state                 = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_n         <= '0;
            r_total     <= NODE_W'(2);
            r_last      <= ROOT_EMPTY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_n         <= n_n;
            r_total     <= n_total;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_sym      <= n_sym;
        r_phase    <= n_phase;
        r_force    <= n_force;
        r_xlen     <= n_xlen;
        r_xlink    <= n_xlink;
        r_cur      <= n_cur;
        r_cur_len  <= n_cur_len;
        r_cur_link <= n_cur_link;
        r_child    <= n_child;
        r_link     <= n_link;
        r_ldepth   <= n_ldepth;
        r_res      <= n_res;
        r_out      <= n_out;
    end

endmodule

@@ rtl/palindromic_tree_builder.sv @@
// Top level of the palindromic tree builder: sequencer and its three memories.
`timescale 1ns / 1ps
//
// Input words carry one lower-case ASCII letter in tdata; tuser set on a word
// clears the tree to its two roots before that letter is taken. Each input word
// gives exactly one output word: the length of the longest palindromic suffix,
// the number of distinct palindromic suffixes ending there, a flag for a newly
// built node and a flag for a letter dropped because the string is full.
// Each suffix-link step reads the node, reads the letter and compares it, but
// a candidate that would start before the first letter is dropped after the node
// read. A letter whose palindrome already exists walks, reads the edge and the
// child node and gives its word; a new node adds a second walk plus the link
// lookup and the write, or only the write when it hangs off the imaginary root.
// A dropped or overflowing letter goes straight to the output. The output word
// becomes valid in the cycle in which the block is ready for the next letter.
// Walks are amortised constant per letter but vary from word to word.
// After reset the edge memory is swept to zero, one entry a cycle, over all 26676
// entries, during which no input word is taken. A finished word waits in the
// output register while the block accepts the next letter; if the receiver
// still stalls when the next word is ready, the sequencer holds until it drains.
//
`include "palindromic_tree_builder_macros.svh"
module palindromic_tree_builder import ptb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [6:0] char_code, [7] zero
    input  logic        i_s_tuser,   // [0] restart
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // [10:0] suffix_pal_len, [21:11] suffix_pal_count,
                                     // [22] node_created, [23] overflow
);

    t_lh_req           w_lh_req;
    t_node_req         w_node_req;
    t_edge_req         w_edge_req;
    logic [SYM_W-1:0]  w_lh_q;
    t_node             w_node_q;
    logic [NODE_W-1:0] w_edge_q;

    ptb_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_lh_req     (w_lh_req),
        .i_lh_rdata   (w_lh_q),
        .o_node_req   (w_node_req),
        .i_node_rdata (w_node_q),
        .o_edge_req   (w_edge_req),
        .i_edge_rdata (w_edge_q)
    );

    ptb_ram #(.DEPTH(HIST_DEPTH), .WIDTH(SYM_W)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_lh_req.we),
        .i_waddr (w_lh_req.waddr),
        .i_wdata (w_lh_req.wdata),
        .i_raddr (w_lh_req.raddr),
        .o_rdata (w_lh_q)
    );

    ptb_ram #(.DEPTH(NODE_CAP), .WIDTH($bits(t_node))) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_node_req.we),
        .i_waddr (w_node_req.waddr),
        .i_wdata (w_node_req.wdata),
        .i_raddr (w_node_req.raddr),
        .o_rdata (w_node_q)
    );

    ptb_ram #(.DEPTH(EDGE_DEPTH), .WIDTH(NODE_W)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_edge_req.we),
        .i_waddr (w_edge_req.waddr),
        .i_wdata (w_edge_req.wdata),
        .i_raddr (w_edge_req.raddr),
        .o_rdata (w_edge_q)
    );

    `PTB_ASSERT_IMPL(a_node_wr_range, i_clk, i_rst_n, w_node_req.we,
        (w_node_req.waddr >= NODE_W'(2)) && (w_node_req.waddr < NODE_W'(NODE_CAP)),
        "node written outside the allocatable range")
    `PTB_ASSERT_IMPL(a_edge_to_new_node, i_clk, i_rst_n,
        w_edge_req.we && (w_edge_req.wdata != '0),
        w_node_req.we && (w_edge_req.wdata == w_node_req.waddr),
        "edge written without its node")
    `PTB_ASSERT_IMPL(a_no_accept_on_write, i_clk, i_rst_n, w_node_req.we, !o_s_tready,
        "input taken while a node is written")
    `PTB_ASSERT_IMPL(a_overflow_clean, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[23],
        o_m_tdata[22:0] == '0, "overflow word carries data")
    `PTB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready,
        !o_s_tready, "second word taken before the first is done")

endmodule
